@@ rtl/mtws_pkg.sv @@
// Shared types and constants for the multi-task watchdog supervisor.
package mtws_pkg;

	// Operation codes carried on the input tuser
	typedef enum logic [1:0] {
		OP_SUBSCRIBE = 2'd0,
		OP_FEED      = 2'd1,
		OP_CHECK     = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOT_EN  = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOT_REG = 2'd3
	} status_t;

	// Configuration register indexes
	localparam logic REG_ENABLED     = 1'b0;
	localparam logic REG_STALE_LIMIT = 1'b1;

	// Field widths
	localparam int OP_W     = 2;
	localparam int TASK_W   = 16;
	localparam int TIME_W   = 32;
	localparam int SLOT_W   = 3;
	localparam int IN_W     = TASK_W + TIME_W;
	localparam int OUT_W    = 16;
	localparam int CFG_W    = 32;

	// Reset value of the stale limit in milliseconds
	localparam logic [TIME_W-1:0] STALE_RESET = 32'd3000;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	// One result item
	typedef struct packed {
		logic                fault_raised;
		logic                fault_latched;
		logic [SLOT_W-1:0]   stale_slot;
		logic                stale_found;
		logic [SLOT_W-1:0]   slot_index;
		status_t             status;
	} result_t;

endpackage

@@ rtl/multi_task_watchdog_supervisor.sv @@
// Multi-task watchdog supervisor: slot table, sequential scan and fault latch.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: operation; tdata: task_id, now_ms
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status .. fault_raised
// cfg       in   cfg_we (no wait)             cfg_index, cfg_wdata
//
// A scanned item has its result registered once the scan and the decide step
// are through: the slot memory is read one entry per cycle and one shared
// subtract/compare unit ages each slot. Refused items and the unused operation
// skip the scan and go straight to the decide step. The decide step registers
// the result once the output register is free; the input is then ready again.
// Reset clears the valid bits, the fault latch and the control registers at once; no
// clearing pass. The block takes one item at a time and holds in its final
// step while the output register is still occupied.
module multi_task_watchdog_supervisor #(
	parameter int SLOTS   = 8,
	parameter int ID_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mtws_pkg::CFG_W-1:0]  cfg_wdata,
	// request stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mtws_pkg::OP_W-1:0]   s_axis_tuser,  // [1:0] operation
	input  logic [mtws_pkg::IN_W-1:0]   s_axis_tdata,  // [15:0] task_id, [47:16] now_ms
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [1:0] status, [4:2] slot_index, [5] stale_found, [8:6] stale_slot,
	// [9] fault_latched, [10] fault_raised, [15:11] zero
	output logic [mtws_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ENTRY_W = ID_BITS + mtws_pkg::TIME_W;
	localparam int RES_W   = $bits(mtws_pkg::result_t);

	// configuration registers
	logic                          enabled_q;
	logic [mtws_pkg::TIME_W-1:0]   stale_limit_q;

	// captured request
	mtws_pkg::op_t                 op_q;
	logic [ID_BITS-1:0]            id_q;
	logic [mtws_pkg::TIME_W-1:0]   now_q;
	logic                          en_q;

	// sequencer
	mtws_pkg::state_t              state_q;
	logic [CNT_W-1:0]              rd_cnt_q;
	logic                          cmp_vld_q;
	logic [IDX_W-1:0]              cmp_idx_q;

	// scan findings
	logic                          hit_q, free_q, stale_q;
	logic [IDX_W-1:0]              hit_idx_q, free_idx_q, stale_idx_q;

	// table
	logic [SLOTS-1:0]              valid_q;
	logic [ENTRY_W-1:0]            mem [SLOTS];
	logic [ENTRY_W-1:0]            rdata_q;
	logic                          fault_q;

	// output register
	logic                          out_vld_q;
	logic [mtws_pkg::OUT_W-1:0]    out_data_q;

	// request decode
	logic                          in_acc;
	logic [ID_BITS+mtws_pkg::TASK_W-1:0] id_ext;
	logic [ID_BITS-1:0]            in_id;

	// scan datapath
	logic                          mem_re;
	logic [IDX_W-1:0]              rd_addr;
	logic [ID_BITS-1:0]            ent_task;
	logic [mtws_pkg::TIME_W-1:0]   ent_feed;
	logic [mtws_pkg::TIME_W-1:0]   age;
	logic                          ent_valid, ent_match, ent_stale;
	logic                          scan_last;

	// decision
	logic                          out_free;
	logic                          advance;
	mtws_pkg::status_t             dec_status;
	logic [IDX_W-1:0]              dec_idx;
	logic                          dec_write;
	logic                          dec_alloc;
	logic                          dec_raise;
	logic [IDX_W+mtws_pkg::SLOT_W-1:0] slot_ext, stale_ext;
	mtws_pkg::result_t             res;

	assign s_axis_tready = (state_q == mtws_pkg::S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign id_ext        = {{ID_BITS{1'b0}}, s_axis_tdata[mtws_pkg::TASK_W-1:0]};
	assign in_id         = id_ext[ID_BITS-1:0];

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			stale_limit_q <= mtws_pkg::STALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtws_pkg::REG_ENABLED:     enabled_q     <= cfg_wdata[0];
				mtws_pkg::REG_STALE_LIMIT: stale_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= mtws_pkg::op_t'(s_axis_tuser);
			id_q  <= in_id;
			now_q <= s_axis_tdata[mtws_pkg::IN_W-1:mtws_pkg::TASK_W];
			en_q  <= enabled_q;
		end
	end

	// Issue one table read per cycle during the scan
	assign mem_re  = (state_q == mtws_pkg::S_SCAN) && (rd_cnt_q < CNT_W'(SLOTS));
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	// Age the entry that came back: one subtract and compare per cycle
	assign ent_task  = rdata_q[ENTRY_W-1:mtws_pkg::TIME_W];
	assign ent_feed  = rdata_q[mtws_pkg::TIME_W-1:0];
	assign age       = now_q - ent_feed;
	assign ent_valid = valid_q[cmp_idx_q];
	assign ent_match = ent_valid && (ent_task == id_q);
	assign ent_stale = ent_valid && (ent_task != id_q) && (op_q == mtws_pkg::OP_CHECK)
	                   && (age > stale_limit_q);
	assign scan_last = cmp_vld_q && (cmp_idx_q == IDX_W'(SLOTS - 1));

	// Decide the outcome once the scan is over
	assign out_free = !out_vld_q || m_axis_tready;
	assign advance  = (state_q == mtws_pkg::S_DECIDE) && out_free;

	always_comb begin
		dec_status = mtws_pkg::ST_OK;
		dec_idx    = '0;
		dec_write  = 1'b0;
		dec_alloc  = 1'b0;
		dec_raise  = 1'b0;
		priority if (!en_q) begin
			dec_status = mtws_pkg::ST_NOT_EN;
		end else if (op_q == mtws_pkg::OP_SUBSCRIBE) begin
			priority if (hit_q) begin
				dec_idx   = hit_idx_q;
				dec_write = 1'b1;
			end else if (free_q) begin
				dec_idx   = free_idx_q;
				dec_write = 1'b1;
				dec_alloc = 1'b1;
			end else begin
				dec_status = mtws_pkg::ST_FULL;
			end
		end else if (op_q == mtws_pkg::OP_FEED || op_q == mtws_pkg::OP_CHECK) begin
			dec_raise = (op_q == mtws_pkg::OP_CHECK) && stale_q && !fault_q;
			if (hit_q) begin
				dec_idx   = hit_idx_q;
				dec_write = 1'b1;
			end else begin
				dec_status = mtws_pkg::ST_NOT_REG;
			end
		end else begin
			dec_status = mtws_pkg::ST_OK;
		end
	end

	assign slot_ext  = {{mtws_pkg::SLOT_W{1'b0}}, dec_idx};
	assign stale_ext = {{mtws_pkg::SLOT_W{1'b0}}, stale_idx_q};

	always_comb begin
		res.status        = dec_status;
		res.slot_index    = slot_ext[mtws_pkg::SLOT_W-1:0];
		res.stale_found   = stale_q;
		res.stale_slot    = stale_ext[mtws_pkg::SLOT_W-1:0];
		res.fault_latched = fault_q || dec_raise;
		res.fault_raised  = dec_raise;
	end

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (advance && dec_write) begin
			mem[dec_idx] <= {id_q, now_q};
		end
		if (mem_re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sequence the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mtws_pkg::S_IDLE;
			rd_cnt_q  <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
		end else begin
			unique case (state_q)
				mtws_pkg::S_IDLE: begin
					rd_cnt_q  <= '0;
					cmp_vld_q <= 1'b0;
					if (in_acc) begin
						if (enabled_q && (mtws_pkg::op_t'(s_axis_tuser) != mtws_pkg::OP_NONE)) begin
							state_q <= mtws_pkg::S_SCAN;
						end else begin
							state_q <= mtws_pkg::S_DECIDE;
						end
					end
				end
				mtws_pkg::S_SCAN: begin
					cmp_vld_q <= mem_re;
					cmp_idx_q <= rd_addr;
					if (mem_re) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (scan_last) begin
						state_q <= mtws_pkg::S_DECIDE;
					end
				end
				mtws_pkg::S_DECIDE: begin
					cmp_vld_q <= 1'b0;
					if (out_free) begin
						state_q <= mtws_pkg::S_IDLE;
					end
				end
				default: state_q <= mtws_pkg::S_IDLE;
			endcase
		end
	end

	// Record the first match, first free slot and first stale slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			stale_q     <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
			stale_idx_q <= '0;
		end else if (in_acc) begin
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			stale_q     <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
			stale_idx_q <= '0;
		end else if (state_q == mtws_pkg::S_SCAN && cmp_vld_q) begin
			if (!hit_q && ent_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_q;
			end
			if (!free_q && !ent_valid) begin
				free_q     <= 1'b1;
				free_idx_q <= cmp_idx_q;
			end
			if (!stale_q && ent_stale) begin
				stale_q     <= 1'b1;
				stale_idx_q <= cmp_idx_q;
			end
		end
	end

	// Update valid bits and the sticky fault latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fault_q <= 1'b0;
		end else if (advance) begin
			if (dec_alloc) begin
				valid_q[dec_idx] <= 1'b1;
			end
			if (dec_raise) begin
				fault_q <= 1'b1;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {{(mtws_pkg::OUT_W - RES_W){1'b0}}, res};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
